/* hw/rtl/splitmix64_random_source_core_assert.svh */
// Assertion macros shared by the splitmix64 random source RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef SPLITMIX64_RANDOM_SOURCE_CORE_ASSERT_SVH
`define SPLITMIX64_RANDOM_SOURCE_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset
`define SM64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SM64_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `SM64_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define SM64_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SM64_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/sm64_pkg.sv */
// Shared constants and types for the splitmix64 random source.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps

package sm64_pkg;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int BOUND_W   = 32;
  localparam int SEED_W    = 32;
  localparam int FRAC_BITS = 53;
  localparam int VALUE_W   = FRAC_BITS;
  localparam int STATE_W   = 64;
  localparam int MUL_W     = 32;

  // Mixing constants
  localparam logic [STATE_W-1:0] SM_INC      = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [STATE_W-1:0] SM_FACTOR_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [STATE_W-1:0] SM_FACTOR_B = 64'h94D0_49BB_1331_11EB;
  localparam int SM_SHIFT_A = 30;
  localparam int SM_SHIFT_B = 27;
  localparam int SM_SHIFT_C = 31;

  // Request codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_RESEED = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FRAC   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INT    = 2'd2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_RESEED,
    OP_FRAC,
    OP_INT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [BOUND_W-1:0] bound;
  } cmd_t;

endpackage

/* hw/rtl/sm64_req_if.sv */
// Request channel interface: valid/ready with func and bound payload.
// Depends on sm64_pkg.
`timescale 1ns / 1ps

interface sm64_req_if
  import sm64_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [BOUND_W-1:0] bound;

  modport source (output valid, output func, output bound, input ready);
  modport sink   (input valid, input func, input bound, output ready);
endinterface

/* hw/rtl/sm64_rsp_if.sv */
// Result channel interface: valid/ready with value and error payload.
// Depends on sm64_pkg.
`timescale 1ns / 1ps

interface sm64_rsp_if
  import sm64_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

/* hw/rtl/sm64_front.sv */
// Front end: accepts requests, classifies them into commands and holds one.
// Depends on sm64_pkg and sm64_req_if.
`timescale 1ns / 1ps

module sm64_front
  import sm64_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sm64_req_if.sink     in_if,
  output logic         push_valid,
  input  logic         push_ready,
  output cmd_t         push_cmd
);

  logic hold_valid_r;
  cmd_t hold_cmd_r;
  cmd_t cls_cmd;

  // Classify the incoming request
  always_comb begin
    cls_cmd.bound = in_if.bound;
    cls_cmd.err   = 1'b0;
    case (in_if.func)
      FUNC_RESEED: cls_cmd.op = OP_RESEED;
      FUNC_FRAC:   cls_cmd.op = OP_FRAC;
      FUNC_INT: begin
        if (in_if.bound == '0) begin
          cls_cmd.op  = OP_NOP;
          cls_cmd.err = 1'b1;
        end else begin
          cls_cmd.op = OP_INT;
        end
      end
      default:     cls_cmd.op = OP_NOP;
    endcase
  end

  // Take a new request whenever the holding stage is empty or draining
  assign in_if.ready = !hold_valid_r || push_ready;
  assign push_valid  = hold_valid_r;
  assign push_cmd    = hold_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      hold_valid_r <= in_if.valid;
    end
  end

  // Capture the command on each transfer
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      hold_cmd_r <= cls_cmd;
    end
  end

endmodule

/* hw/rtl/sm64_queue.sv */
// Short command queue decoupling the front end from the execution unit.
// Depends on sm64_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "splitmix64_random_source_core_assert.svh"

module sm64_queue
  import sm64_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SM64_ASSERT(a_queue_no_overflow, cnt_r <= QCNT_W'(QUEUE_DEPTH), "queue occupancy beyond depth")

endmodule

/* hw/rtl/sm64_back.sv */
// Execution unit: generator state, seed register, shared 32x32 multiplier
// sequencer and the result output register. Depends on sm64_pkg, sm64_rsp_if
// and the assertion macro header.
`timescale 1ns / 1ps
`include "splitmix64_random_source_core_assert.svh"

module sm64_back
  import sm64_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SEED_W-1:0] cfg_wdata,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cmd_t              pop_cmd,
  sm64_rsp_if.source        out_if
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_M1A,
    ST_M1B,
    ST_M1C,
    ST_M2A,
    ST_M2B,
    ST_M2C,
    ST_S1,
    ST_S2,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [SEED_W-1:0]    seed_r;
  logic [STATE_W-1:0]   gs_r;
  logic [STATE_W-1:0]   z_r;
  logic [STATE_W-1:0]   acc_r;
  op_t                  op_r;
  logic [BOUND_W-1:0]   bound_r;
  logic [VALUE_W-1:0]   res_value_r;
  logic                 res_error_r;
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_error_r;

  logic [MUL_W-1:0]     mul_x;
  logic [MUL_W-1:0]     mul_y;
  logic [2*MUL_W-1:0]   prod;
  logic [STATE_W-1:0]   mac_sum;
  logic [STATE_W-1:0]   adv_sum;
  logic [FRAC_BITS-1:0] frac;
  logic                 out_load;

  assign frac     = z_r[STATE_W-1 -: FRAC_BITS];
  assign adv_sum  = gs_r + SM_INC;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  assign pop_ready    = (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.value = out_value_r;
  assign out_if.error = out_error_r;

  // Select multiplier operands for the current step
  always_comb begin
    case (state_r)
      ST_M1A:  begin mul_x = z_r[MUL_W-1:0];       mul_y = SM_FACTOR_A[MUL_W-1:0];       end
      ST_M1B:  begin mul_x = z_r[STATE_W-1:MUL_W]; mul_y = SM_FACTOR_A[MUL_W-1:0];       end
      ST_M1C:  begin mul_x = z_r[MUL_W-1:0];       mul_y = SM_FACTOR_A[STATE_W-1:MUL_W]; end
      ST_M2A:  begin mul_x = z_r[MUL_W-1:0];       mul_y = SM_FACTOR_B[MUL_W-1:0];       end
      ST_M2B:  begin mul_x = z_r[STATE_W-1:MUL_W]; mul_y = SM_FACTOR_B[MUL_W-1:0];       end
      ST_M2C:  begin mul_x = z_r[MUL_W-1:0];       mul_y = SM_FACTOR_B[STATE_W-1:MUL_W]; end
      ST_S1:   begin mul_x = frac[MUL_W-1:0];      mul_y = bound_r;                      end
      ST_S2:   begin mul_x = MUL_W'(frac >> MUL_W); mul_y = bound_r;                     end
      default: begin mul_x = '0;                   mul_y = '0;                           end
    endcase
  end

  assign prod = mul_x * mul_y;

  // Accumulate partial products; cross terms land in the upper word
  always_comb begin
    case (state_r)
      ST_M1B, ST_M1C, ST_M2B, ST_M2C:
        mac_sum = acc_r + {prod[MUL_W-1:0], {MUL_W{1'b0}}};
      ST_S2:
        mac_sum = prod + {{MUL_W{1'b0}}, acc_r[STATE_W-1:MUL_W]};
      default:
        mac_sum = prod;
    endcase
  end

  // Sequencer, generator state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      gs_r        <= '0;
    end else begin
      if (cfg_we) seed_r <= cfg_wdata;

      if (out_load)           out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            op_r        <= pop_cmd.op;
            bound_r     <= pop_cmd.bound;
            res_value_r <= '0;
            res_error_r <= pop_cmd.err;
            case (pop_cmd.op)
              OP_RESEED: begin
                gs_r    <= {{(STATE_W-SEED_W){1'b0}}, seed_r};
                state_r <= ST_DONE;
              end
              OP_FRAC, OP_INT: state_r <= ST_ADV;
              default:         state_r <= ST_DONE;
            endcase
          end
        end
        ST_ADV: begin
          gs_r    <= adv_sum;
          z_r     <= adv_sum ^ (adv_sum >> SM_SHIFT_A);
          state_r <= ST_M1A;
        end
        ST_M1A: begin acc_r <= mac_sum; state_r <= ST_M1B; end
        ST_M1B: begin acc_r <= mac_sum; state_r <= ST_M1C; end
        ST_M1C: begin
          z_r     <= mac_sum ^ (mac_sum >> SM_SHIFT_B);
          state_r <= ST_M2A;
        end
        ST_M2A: begin acc_r <= mac_sum; state_r <= ST_M2B; end
        ST_M2B: begin acc_r <= mac_sum; state_r <= ST_M2C; end
        ST_M2C: begin
          z_r         <= mac_sum ^ (mac_sum >> SM_SHIFT_C);
          res_value_r <= FRAC_BITS'((mac_sum ^ (mac_sum >> SM_SHIFT_C))
                                    >> (STATE_W - FRAC_BITS));
          state_r     <= (op_r == OP_INT) ? ST_S1 : ST_DONE;
        end
        ST_S1: begin acc_r <= mac_sum; state_r <= ST_S2; end
        ST_S2: begin
          res_value_r <= VALUE_W'(mac_sum >> (FRAC_BITS - MUL_W));
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_value_r <= res_value_r;
            out_error_r <= res_error_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SM64_ASSERT_IMPLY(a_err_value_zero, out_valid_r && out_error_r, out_value_r == '0, "error result with nonzero value")
  `SM64_ASSERT_IMPLY(a_scale_only_int, state_r == ST_S1 || state_r == ST_S2, op_r == OP_INT, "scaling step outside integer draw")
  `SM64_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_r, "result load did not raise valid")

endmodule

/* hw/rtl/splitmix64_random_source_core.sv */
// splitmix64 random source. Each request (reseed, fraction draw or integer
// draw below a bound) yields exactly one result. Requests are classified in a
// front stage and held in a two-entry queue; the execution unit serves one at
// a time with a single 32x32 multiplier. A fraction draw passes the execution
// unit as an accept step, a state advance, three partial products for each of
// the two 64-bit mixing multiplies and a result load; an integer draw adds two
// more partial products for the exact scaling by the bound; a reseed, an
// integer draw with zero bound or an unused selector goes from accept straight
// to the result load. A result held by a stalled receiver keeps the
// execution unit in its load cycle until the output register frees up. The
// seed register loads via cfg_we/cfg_wdata.
// Depends on sm64_pkg, sm64_req_if, sm64_rsp_if, sm64_front, sm64_queue and
// sm64_back.
`timescale 1ns / 1ps

module splitmix64_random_source_core
  import sm64_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SEED_W-1:0] cfg_wdata,
  sm64_req_if.sink          in_if,
  sm64_rsp_if.source        out_if
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Accept and classify requests
  sm64_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Buffer commands between the two halves
  sm64_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Execute commands and drive results
  sm64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_if    (out_if)
  );

endmodule
